@@ rtl/core/postfix_stack_evaluator_core_macros.svh @@
// Assertion macros shared by the postfix evaluator RTL.
`ifndef POSTFIX_STACK_EVALUATOR_CORE_MACROS_SVH
`define POSTFIX_STACK_EVALUATOR_CORE_MACROS_SVH
`ifndef SYNTH
`define PSED_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define PSED_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define PSED_ASSERT(lbl, clk, rstn, prop)
`define PSED_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

@@ rtl/core/psed_pkg.sv @@
// Types, codes and sizes shared by the postfix evaluator modules.
`default_nettype none
package psed_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int NUM_VARS    = 32;

  localparam int CMD_W    = 3;
  localparam int LIT_W    = 31;
  localparam int VIDX_W   = 5;
  localparam int STATUS_W = 3;
  localparam int DATA_W   = 32;

  localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
  localparam int SADDR_W = $clog2(STACK_DEPTH);
  localparam int VADDR_W = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
  localparam int DCNT_W  = $clog2(DATA_W);

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 3'd0,
    CMD_LOAD  = 3'd1,
    CMD_STORE = 3'd2,
    CMD_ADD   = 3'd3,
    CMD_SUB   = 3'd4,
    CMD_MUL   = 3'd5,
    CMD_DIV   = 3'd6,
    CMD_END   = 3'd7
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK      = 3'd0,
    STS_FEW     = 3'd1,
    STS_MISSING = 3'd2,
    STS_DIVZERO = 3'd3,
    STS_OVERFLOW = 3'd4
  } status_e;

  typedef struct packed {
    logic               stk_re;
    logic [SADDR_W-1:0] stk_raddr;
    logic               stk_we;
    logic [SADDR_W-1:0] stk_waddr;
    logic [DATA_W-1:0]  stk_wdata;
    logic               var_re;
    logic [VADDR_W-1:0] var_raddr;
    logic               var_we;
    logic [VADDR_W-1:0] var_waddr;
    logic [DATA_W-1:0]  var_wdata;
    logic               var_clear;
  } stor_req_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

@@ rtl/core/psed_stream_if.sv @@
// Valid/ready channel interfaces for command items and result items.
`default_nettype none
interface psed_cmd_if import psed_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [LIT_W-1:0]  literal_value;
  logic [VIDX_W-1:0] var_index;

  modport source (output valid, output command, output literal_value, output var_index,
                  input ready);
  modport sink   (input valid, input command, input literal_value, input var_index,
                  output ready);
endinterface

interface psed_res_if import psed_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [DATA_W-1:0] result_value;
  logic                     expression_done;

  modport source (output valid, output status, output result_value,
                  output expression_done, input ready);
  modport sink   (input valid, input status, input result_value,
                  input expression_done, output ready);
endinterface
`default_nettype wire

@@ rtl/core/psed_div.sv @@
// Radix-2 restoring divider for signed 32-bit operands, truncating toward zero.
`default_nettype none
`include "postfix_stack_evaluator_core_macros.svh"
module psed_div import psed_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  logic              busy_q, done_q;
  logic [DCNT_W-1:0] cnt_q;
  logic [DATA_W-1:0] rem_q, quo_q, dsr_q;
  logic              neg_q;
  logic [DATA_W:0]   trial;
  logic [DATA_W-1:0] mag_a, mag_b;

  assign mag_a = req_i.dividend[DATA_W-1] ? (DATA_W'(0) - req_i.dividend) : req_i.dividend;
  assign mag_b = req_i.divisor[DATA_W-1] ? (DATA_W'(0) - req_i.divisor) : req_i.divisor;
  assign trial = {rem_q, quo_q[DATA_W-1]} - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + DCNT_W'(1);
      if (cnt_q == DCNT_W'(DATA_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= mag_a;
      dsr_q <= mag_b;
      neg_q <= req_i.dividend[DATA_W-1] ^ req_i.divisor[DATA_W-1];
    end else if (busy_q) begin
      if (!trial[DATA_W]) begin
        rem_q <= trial[DATA_W-1:0];
        quo_q <= {quo_q[DATA_W-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[DATA_W-2:0], quo_q[DATA_W-1]};
        quo_q <= {quo_q[DATA_W-2:0], 1'b0};
      end
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = neg_q ? (DATA_W'(0) - quo_q) : quo_q;

  `PSED_ASSERT_NEVER(a_no_start_busy, clk_i, rst_ni, req_i.start && busy_q)
  `PSED_ASSERT_NEVER(a_busy_done_excl, clk_i, rst_ni, busy_q && done_q)
  `PSED_ASSERT(a_last_step_done, clk_i, rst_ni,
               (busy_q && !req_i.start && cnt_q == DCNT_W'(DATA_W - 1)) |=> done_q)

endmodule
`default_nettype wire

@@ rtl/core/psed_store.sv @@
// Operand stack memory, variable memory and the variable defined flags.
`default_nettype none
module psed_store import psed_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire stor_req_t   req_i,
  output logic [DATA_W-1:0] stk_rdata_o,
  output logic [DATA_W-1:0] var_rdata_o,
  output logic              var_def_o
);

  logic [DATA_W-1:0] stk_mem [STACK_DEPTH];
  logic [DATA_W-1:0] var_mem [NUM_VARS];
  logic [NUM_VARS-1:0] def_q;
  logic                def_rd_q;
  logic [DATA_W-1:0]   stk_rd_q, var_rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.stk_we) begin
      stk_mem[req_i.stk_waddr] <= req_i.stk_wdata;
    end
    if (req_i.stk_re) begin
      stk_rd_q <= stk_mem[req_i.stk_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.var_we) begin
      var_mem[req_i.var_waddr] <= req_i.var_wdata;
    end
    if (req_i.var_re) begin
      var_rd_q <= var_mem[req_i.var_raddr];
    end
  end

  // Flags live in flip-flops so that the end of an expression clears them at once.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      def_q    <= '0;
      def_rd_q <= 1'b0;
    end else begin
      if (req_i.var_clear) begin
        def_q <= '0;
      end else if (req_i.var_we) begin
        def_q[req_i.var_waddr] <= 1'b1;
      end
      if (req_i.var_re) begin
        def_rd_q <= def_q[req_i.var_raddr];
      end
    end
  end

  assign stk_rdata_o = stk_rd_q;
  assign var_rdata_o = var_rd_q;
  assign var_def_o   = def_rd_q;

endmodule
`default_nettype wire

@@ rtl/core/postfix_stack_evaluator_core.sv @@
// Top level of the postfix expression evaluator: sequencer, stack pointer and result register.
//
//   channel  | dir | handshake   | payload
//   ---------+-----+-------------+------------------------------------------------
//   cmd_i    | in  | valid/ready | command[2:0], literal_value[30:0], var_index[4:0]
//   res_o    | out | valid/ready | status[2:0], result_value[31:0] signed,
//            |     |             | expression_done
//
// The accept cycle issues the reads of the stack and variable memories; the item then
// uses the registered read data and commits once the output register is free.
// A divide waits in ST_DIVW for the divider, which produces one quotient bit per cycle.
// Reset clears the stack count, the sticky error and the variable defined flags at
// once; no clearing pass is needed and items are accepted right after reset.
// A result waits in the output register; the next item may be accepted meanwhile,
// and only its commit waits until the output register is free.
`default_nettype none
`include "postfix_stack_evaluator_core_macros.svh"
module postfix_stack_evaluator_core import psed_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  psed_cmd_if.sink   cmd_i,
  psed_res_if.source res_o
);

  // One item is in flight at a time, so a memory write at commit is always
  // settled before the reads of the next item are issued.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_DIVW = 3'b100
  } state_e;

  state_e            state_q;
  cmd_e              cmd_q;
  logic [LIT_W-1:0]  lit_q;
  logic [VIDX_W-1:0] idx_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DATA_W-1:0] top_q, top_d;
  status_e           err_q, err_d;

  logic                out_valid_q;
  logic [STATUS_W-1:0] out_sts_q;
  logic [DATA_W-1:0]   out_val_q;
  logic                out_done_q;

  logic in_accept, out_free, commit, go_div, commit_end;
  logic stk_wr, var_wr, var_clr;
  logic has1, has2, full, in_range;
  status_e end_sts;
  logic [DATA_W-1:0] stk_rdata, var_rdata, push_val, lhs, rhs;
  logic              var_def;
  stor_req_t         st_req;
  div_req_t          dv_req;
  div_rsp_t          dv_rsp;
  logic [STATUS_W-1:0] res_sts;
  logic [DATA_W-1:0]   res_val;

  assign in_accept = cmd_i.valid && cmd_i.ready;
  assign cmd_i.ready = (state_q == ST_IDLE);
  assign out_free = !out_valid_q || res_o.ready;

  assign has1     = (cnt_q != '0);
  assign has2     = (cnt_q >= CNT_W'(2));
  assign full     = (cnt_q == CNT_W'(STACK_DEPTH));
  assign in_range = (int'(idx_q) < NUM_VARS);

  // Top of stack sits in top_q; the memory holds the entries below it.
  assign lhs = stk_rdata;
  assign rhs = top_q;
  assign push_val = (cmd_q == CMD_PUSH) ? DATA_W'(lit_q) :
                    ((in_range && var_def) ? var_rdata : '0);

  always_comb begin
    cnt_d   = cnt_q;
    top_d   = top_q;
    err_d   = err_q;
    commit  = 1'b0;
    go_div  = 1'b0;
    stk_wr  = 1'b0;
    var_wr  = 1'b0;
    var_clr = 1'b0;
    end_sts = STS_OK;
    case (state_q)
      ST_EXEC: begin
        if (cmd_q == CMD_END) begin
          commit = out_free;
          if (err_q != STS_OK) begin
            end_sts = err_q;
          end else if (!has1) begin
            end_sts = STS_FEW;
          end else if (has2) begin
            end_sts = STS_MISSING;
          end else begin
            end_sts = STS_OK;
          end
          cnt_d   = '0;
          err_d   = STS_OK;
          var_clr = commit;
        end else if (err_q != STS_OK) begin
          // Sticky error: the item changes nothing and reports the error.
          commit = out_free;
        end else begin
          case (cmd_q)
            CMD_PUSH, CMD_LOAD: begin
              commit = out_free;
              if (full) begin
                err_d = STS_OVERFLOW;
              end else begin
                top_d  = push_val;
                cnt_d  = cnt_q + CNT_W'(1);
                stk_wr = has1 && commit;
              end
            end
            CMD_STORE: begin
              commit = out_free;
              if (!has1) begin
                err_d = STS_FEW;
              end else begin
                top_d  = lhs;
                cnt_d  = cnt_q - CNT_W'(1);
                // Only the first store to a variable takes effect.
                var_wr = commit && in_range && !var_def;
              end
            end
            CMD_ADD, CMD_SUB, CMD_MUL: begin
              commit = out_free;
              if (!has2) begin
                err_d = STS_FEW;
              end else begin
                cnt_d = cnt_q - CNT_W'(1);
                if (cmd_q == CMD_ADD) begin
                  top_d = lhs + rhs;
                end else if (cmd_q == CMD_SUB) begin
                  top_d = lhs - rhs;
                end else begin
                  top_d = lhs * rhs;
                end
              end
            end
            CMD_DIV: begin
              if (!has2) begin
                commit = out_free;
                err_d  = STS_FEW;
              end else if (rhs == '0) begin
                commit = out_free;
                err_d  = STS_DIVZERO;
              end else begin
                go_div = 1'b1;
              end
            end
            default: begin
              commit = out_free;
            end
          endcase
        end
      end
      ST_DIVW: begin
        if (dv_rsp.done) begin
          commit = out_free;
          top_d  = dv_rsp.quotient;
          cnt_d  = cnt_q - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign commit_end = commit && (cmd_q == CMD_END);

  // The end item reports its own status; any other item reports the error and the
  // top of the stack as they stand after it.
  always_comb begin
    if (cmd_q == CMD_END) begin
      res_sts = end_sts;
      res_val = (end_sts == STS_OK) ? top_q : '0;
    end else begin
      res_sts = err_d;
      res_val = (cnt_d != '0) ? top_d : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      err_q   <= STS_OK;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (go_div) begin
            state_q <= ST_DIVW;
          end else if (commit) begin
            state_q <= ST_IDLE;
          end
        end
        ST_DIVW: begin
          if (commit) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
      if (commit) begin
        cnt_q <= cnt_d;
        err_q <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q <= cmd_e'(cmd_i.command);
      lit_q <= cmd_i.literal_value;
      idx_q <= cmd_i.var_index;
    end
    if (commit) begin
      top_q <= top_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_sts_q  <= res_sts;
      out_val_q  <= res_val;
      out_done_q <= (cmd_q == CMD_END);
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.status          = out_sts_q;
  assign res_o.result_value    = out_val_q;
  assign res_o.expression_done = out_done_q;

  // Reads are issued in the accept cycle; the variable address comes from the incoming item.
  assign st_req.stk_re    = in_accept;
  assign st_req.stk_raddr = SADDR_W'(cnt_q - CNT_W'(2));
  assign st_req.stk_we    = stk_wr;
  assign st_req.stk_waddr = SADDR_W'(cnt_q - CNT_W'(1));
  assign st_req.stk_wdata = top_q;
  assign st_req.var_re    = in_accept;
  assign st_req.var_raddr = VADDR_W'(cmd_i.var_index);
  assign st_req.var_we    = var_wr;
  assign st_req.var_waddr = VADDR_W'(idx_q);
  assign st_req.var_wdata = top_q;
  assign st_req.var_clear = var_clr;

  psed_store u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (st_req),
    .stk_rdata_o (stk_rdata),
    .var_rdata_o (var_rdata),
    .var_def_o   (var_def)
  );

  assign dv_req.start    = go_div;
  assign dv_req.dividend = lhs;
  assign dv_req.divisor  = rhs;

  psed_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dv_req),
    .rsp_o  (dv_rsp)
  );

  `PSED_ASSERT(a_accept_to_exec, clk_i, rst_ni, in_accept |=> (state_q == ST_EXEC))
  `PSED_ASSERT_NEVER(a_cnt_bound, clk_i, rst_ni, cnt_q > CNT_W'(STACK_DEPTH))
  `PSED_ASSERT(a_err_sticky, clk_i, rst_ni,
               ((err_q != STS_OK) && !commit_end) |=> (err_q == $past(err_q)))
  `PSED_ASSERT_NEVER(a_end_err_zero, clk_i, rst_ni,
                     out_valid_q && out_done_q && (out_sts_q != STS_OK) && (out_val_q != '0))

endmodule
`default_nettype wire
